// ===== hdl/tstr_pkg.sv =====
package tstr_pkg;

    localparam int MAX_ITEMS_DEF = 64;

    localparam int VALUE_W = 32;
    localparam int KEY_W   = VALUE_W + 1;   // order-mapped value, tag in the lsb
    localparam int RANK_W  = 8;
    localparam int GSIZE_W = 7;

    typedef logic [KEY_W-1:0] t_key;

    // per-cycle command from the sequencer to every cell of the chain
    typedef struct packed {
        logic insert_en;   // sort step plus tie-count relaxation
        logic shift_en;    // move contents one cell toward the head
    } t_cell_ctl;

    // signed value -> unsigned order, tag breaks ties (0 before 1)
    function automatic t_key make_key(input logic [VALUE_W-1:0] value, input logic tag);
        make_key = {~value[VALUE_W-1], value[VALUE_W-2:0], tag};
    endfunction

endpackage

// ===== hdl/tstr_if.sv =====
interface tstr_in_if;
    logic                        valid;
    logic                        ready;
    logic [tstr_pkg::VALUE_W-1:0] sample_value;
    logic                        second_sample;
    logic                        final_item;

    modport source (output valid, sample_value, second_sample, final_item, input ready);
    modport sink   (input valid, sample_value, second_sample, final_item, output ready);
endinterface

interface tstr_out_if;
    logic                        valid;
    logic                        ready;
    logic                        from_second;
    logic [tstr_pkg::RANK_W-1:0]  rank_twice;
    logic [tstr_pkg::GSIZE_W-1:0] group_size;
    logic                        group_start;
    logic                        dropped;
    logic                        run_end;

    modport source (output valid, from_second, rank_twice, group_size, group_start,
                    dropped, run_end, input ready);
    modport sink   (input valid, from_second, rank_twice, group_size, group_start,
                    dropped, run_end, output ready);
endinterface

// ===== hdl/tstr_cell.sv =====
module tstr_cell #(
    parameter int CNT_W = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tstr_pkg::t_cell_ctl  i_ctl,
    input  tstr_pkg::t_key       i_ins_key,
    input  logic                 i_ins_vld,
    input  tstr_pkg::t_key       i_nxt_key,
    input  logic                 i_nxt_vld,
    input  logic [CNT_W-1:0]     i_nxt_cnt,
    output tstr_pkg::t_key       o_key,
    output logic                 o_vld,
    output logic [CNT_W-1:0]     o_cnt,
    output tstr_pkg::t_key       o_pass_key,
    output logic                 o_pass_vld
);

    tstr_pkg::t_key   r_key, n_key;
    logic             r_vld, n_vld;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    tstr_pkg::t_key   r_pass_key, n_pass_key;
    logic             r_pass_vld, n_pass_vld;
    logic             w_same;

    // same value as the next cell (tag ignored)
    assign w_same = r_vld && i_nxt_vld &&
                    (r_key[tstr_pkg::KEY_W-1:1] == i_nxt_key[tstr_pkg::KEY_W-1:1]);

    always_comb begin
        n_key      = r_key;
        n_vld      = r_vld;
        n_cnt      = r_cnt;
        n_pass_key = r_pass_key;
        n_pass_vld = 1'b0;
        if (i_ctl.shift_en) begin
            n_key = i_nxt_key;
            n_vld = i_nxt_vld;
            n_cnt = i_nxt_cnt;
        end else if (i_ctl.insert_en) begin
            // run length from here to the end of the tie group
            n_cnt = w_same ? (i_nxt_cnt + CNT_W'(1)) : CNT_W'(1);
            if (i_ins_vld) begin
                if (!r_vld) begin
                    n_key = i_ins_key;
                    n_vld = 1'b1;
                end else if (i_ins_key < r_key) begin
                    n_key      = i_ins_key;
                    n_pass_key = r_key;
                    n_pass_vld = 1'b1;
                end else begin
                    n_pass_key = i_ins_key;
                    n_pass_vld = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            r_vld      <= n_vld;
            r_pass_vld <= n_pass_vld;
        end
        r_key      <= n_key;
        r_cnt      <= n_cnt;
        r_pass_key <= n_pass_key;
    end

    assign o_key      = r_key;
    assign o_vld      = r_vld;
    assign o_cnt      = r_cnt;
    assign o_pass_key = r_pass_key;
    assign o_pass_vld = r_pass_vld;

endmodule

// ===== hdl/two_sample_tied_rank_top.sv =====
// Channel   Dir  Payload                                                  Accepted when
// i_in      in   sample_value[31:0] second_sample final_item              valid && ready
// o_out     out  from_second rank_twice[7:0] group_size[6:0]              valid && ready
//                group_start dropped run_end
//
// Load: one item per cycle; ready is high only in the load phase.
// After the final item: a settle phase (sort drain through the cell chain,
// then tie-count relaxation along it), then one result per cycle while
// o_out.ready is high. The settle length is set by the chain depth.
// A stalled output simply holds the chain; the next data set is taken once
// the last result of the run has been accepted.
// Reset (synchronous, active low) empties the chain and returns to load.
module two_sample_tied_rank_top #(
    parameter int MAX_ITEMS = tstr_pkg::MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tstr_in_if.sink     i_in,
    tstr_out_if.source  o_out
);

    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int SETTLE_N = 2 * MAX_ITEMS;
    localparam int TMR_W    = $clog2(SETTLE_N);

    typedef enum logic [1:0] {ST_LOAD, ST_SETTLE, ST_EMIT} t_state;

    t_state r_state;

    logic [CNT_W-1:0] r_count;      // items stored in this data set
    logic             r_ovf;        // something was dropped
    logic [TMR_W-1:0] r_tmr;        // settle timer
    logic [CNT_W-1:0] r_emit_k;     // results handed to the output register
    logic [CNT_W-1:0] r_grp_pos;    // sorted position of current group head
    logic [CNT_W-1:0] r_grp_size;
    logic [tstr_pkg::VALUE_W-1:0] r_prev_val;

    // output register
    logic                         r_ov;
    logic                         r_o_from_second;
    logic [tstr_pkg::RANK_W-1:0]  r_o_rank;
    logic [tstr_pkg::GSIZE_W-1:0] r_o_gsize;
    logic                         r_o_gstart;
    logic                         r_o_dropped;
    logic                         r_o_run_end;

    // chain wiring
    tstr_pkg::t_key   w_key      [MAX_ITEMS];
    logic             w_vld      [MAX_ITEMS];
    logic [CNT_W-1:0] w_cnt      [MAX_ITEMS];
    tstr_pkg::t_key   w_pass_key [MAX_ITEMS];
    logic             w_pass_vld [MAX_ITEMS];

    tstr_pkg::t_cell_ctl w_ctl;

    logic w_in_acc;
    logic w_store;
    logic w_take;       // output register can take a new result
    logic w_emit;       // a result moves from the chain head this cycle
    logic w_head_start;
    logic [tstr_pkg::VALUE_W-1:0] w_head_val;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_gsize;
    logic [tstr_pkg::RANK_W-1:0] w_rank;
    tstr_pkg::t_key w_ins_key;

    assign i_in.ready = (r_state == ST_LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_store    = w_in_acc && (r_count != CNT_W'(MAX_ITEMS));
    assign w_ins_key  = tstr_pkg::make_key(i_in.sample_value, i_in.second_sample);

    assign w_take = !r_ov || o_out.ready;
    assign w_emit = (r_state == ST_EMIT) && w_take && (r_emit_k != r_count);

    assign w_ctl.shift_en  = w_emit;
    assign w_ctl.insert_en = (r_state != ST_EMIT);

    // ---------------- cell chain: head is cell 0, ascending order --------------
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        tstr_pkg::t_key   w_in_k;
        logic             w_in_v;
        tstr_pkg::t_key   w_nx_k;
        logic             w_nx_v;
        logic [CNT_W-1:0] w_nx_c;

        if (g == 0) begin : g_head
            assign w_in_k = w_ins_key;
            assign w_in_v = w_store;
        end else begin : g_body
            assign w_in_k = w_pass_key[g-1];
            assign w_in_v = w_pass_vld[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_nx_k = '0;
            assign w_nx_v = 1'b0;
            assign w_nx_c = '0;
        end else begin : g_link
            assign w_nx_k = w_key[g+1];
            assign w_nx_v = w_vld[g+1];
            assign w_nx_c = w_cnt[g+1];
        end

        tstr_cell #(.CNT_W(CNT_W)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_ins_key  (w_in_k),
            .i_ins_vld  (w_in_v),
            .i_nxt_key  (w_nx_k),
            .i_nxt_vld  (w_nx_v),
            .i_nxt_cnt  (w_nx_c),
            .o_key      (w_key[g]),
            .o_vld      (w_vld[g]),
            .o_cnt      (w_cnt[g]),
            .o_pass_key (w_pass_key[g]),
            .o_pass_vld (w_pass_vld[g])
        );
    end

    // ---------------- result formation at the chain head ----------------------
    // undo the order mapping to recover the raw value bits
    assign w_head_val   = {~w_key[0][tstr_pkg::KEY_W-1], w_key[0][tstr_pkg::KEY_W-2:1]};
    assign w_head_start = (r_emit_k == '0) || (w_head_val != r_prev_val);
    // at a group head, the cell's run length is the whole group size
    assign w_pos   = w_head_start ? r_emit_k : r_grp_pos;
    assign w_gsize = w_head_start ? w_cnt[0] : r_grp_size;
    // 2*start + 1 + size
    assign w_rank  = (tstr_pkg::RANK_W'(w_pos) << 1) + tstr_pkg::RANK_W'(1)
                   + tstr_pkg::RANK_W'(w_gsize);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_tmr    <= '0;
            r_emit_k <= '0;
            r_ov     <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (w_store) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.final_item) begin
                            r_state <= ST_SETTLE;
                            r_tmr   <= '0;
                        end
                    end
                end
                ST_SETTLE: begin
                    r_tmr <= r_tmr + TMR_W'(1);
                    if (r_tmr == TMR_W'(SETTLE_N - 1)) begin
                        r_state  <= ST_EMIT;
                        r_emit_k <= '0;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_ov     <= 1'b1;
                        r_emit_k <= r_emit_k + CNT_W'(1);
                    end else if (o_out.ready) begin
                        r_ov <= 1'b0;
                    end
                    // run done once the last result has left the output register
                    if (r_emit_k == r_count && w_take) begin
                        r_state <= ST_LOAD;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end

        // payload, no reset
        if (w_emit) begin
            r_o_from_second <= w_key[0][0];
            r_o_rank        <= w_rank;
            r_o_gsize       <= tstr_pkg::GSIZE_W'(w_gsize);
            r_o_gstart      <= w_head_start;
            r_o_dropped     <= r_ovf;
            r_o_run_end     <= (r_emit_k + CNT_W'(1)) == r_count;
            r_prev_val      <= w_head_val;
            r_grp_pos       <= w_pos;
            r_grp_size      <= w_gsize;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.from_second = r_o_from_second;
    assign o_out.rank_twice  = r_o_rank;
    assign o_out.group_size  = r_o_gsize;
    assign o_out.group_start = r_o_gstart;
    assign o_out.dropped     = r_o_dropped;
    assign o_out.run_end     = r_o_run_end;

    // ---------------- assertions ----------------
    // the chain head must hold an element for every result still owed
    a_head_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_vld[0])
        else $error("chain head empty while results are owed");

    // the last result of a run is shown only after all results were issued
    a_run_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.run_end) |-> (r_emit_k == r_count))
        else $error("run_end before all results issued");

    // no stale result remains while a new data set is being loaded
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_ov)
        else $error("result pending during load");

    // the store never counts past its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    // a dropped item leaves the count unchanged
    a_drop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_store) |=> (r_count == $past(r_count)) || (r_state != ST_LOAD))
        else $error("count moved on a dropped item");

endmodule
